>>> rtl/cls_pkg.sv
// Package for the connection lifecycle supervisor.
// Holds link state, action and verdict codes, configuration reset values and shared types.
// No dependencies.
`timescale 1ns / 1ps

package cls_pkg;

	// Link states.
	localparam logic [2:0] ST_INVALID = 3'd0;
	localparam logic [2:0] ST_OPENING = 3'd1;
	localparam logic [2:0] ST_OPENED  = 3'd2;
	localparam logic [2:0] ST_CLOSING = 3'd3;
	localparam logic [2:0] ST_CLOSED  = 3'd4;

	// Heartbeat phases.
	localparam logic [1:0] HB_NONE     = 2'd0;
	localparam logic [1:0] HB_CHECKING = 2'd1;
	localparam logic [1:0] HB_DONE     = 2'd2;

	// Requested actions.
	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_OPEN  = 3'd1;
	localparam logic [2:0] ACT_HEART = 3'd2;
	localparam logic [2:0] ACT_CLOSE = 3'd3;
	localparam logic [2:0] ACT_ABORT = 3'd4;

	// Check verdicts.
	localparam logic [1:0] V_INVALID = 2'd0;
	localparam logic [1:0] V_SUCCESS = 2'd1;
	localparam logic [1:0] V_ABORT   = 2'd2;

	// Commands.
	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_REOPEN_DELAY = 3'd0;
	localparam logic [2:0] REG_ABORT_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_HB_INTERVAL = 3'd2;
	localparam logic [2:0] REG_AUTO_REOPEN = 3'd3;
	localparam logic [2:0] REG_HB_ON_OPEN = 3'd4;

	localparam int CFG_W = 31;
	localparam int NOW_W = 32;

	localparam logic [CFG_W-1:0] RST_REOPEN_DELAY = 31'd3000;
	localparam logic [CFG_W-1:0] RST_ABORT_TIMEOUT = 31'd30000;
	localparam logic [CFG_W-1:0] RST_HB_INTERVAL = 31'd10000;

	// Configuration register set.
	typedef struct packed {
		logic [CFG_W-1:0] reopen_delay;
		logic [CFG_W-1:0] abort_timeout;
		logic [CFG_W-1:0] heartbeat_interval;
		logic             auto_reopen;
		logic             heartbeat_on_open;
	} cfg_t;

	// Control state of the link, apart from the tick mark.
	typedef struct packed {
		logic [2:0] link_status;
		logic [1:0] hb_phase;
		logic       abort_pending;
		logic [7:0] busy;
	} ctl_t;

endpackage

>>> rtl/cls_step_logic.sv
// Next-state and result logic for one transaction of the lifecycle supervisor.
// Purely combinational; depends on cls_pkg.
`timescale 1ns / 1ps

module cls_step_logic #(
	parameter int TICK_WIDTH = 32
) (
	input  logic                    command,
	input  logic [TICK_WIDTH-1:0]   now,
	input  logic signed [7:0]       result,
	input  cls_pkg::cfg_t           cfg,
	input  cls_pkg::ctl_t           ctl,
	input  logic [TICK_WIDTH-1:0]   mark,
	output cls_pkg::ctl_t           ctl_next,
	output logic [TICK_WIDTH-1:0]   mark_next,
	output logic [1:0]              verdict,
	output logic [2:0]              action,
	output logic signed [7:0]       step_return
);
	import cls_pkg::*;

	localparam int CW = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

	logic [TICK_WIDTH-1:0] diff;
	logic [CW-1:0]         elapsed;
	logic [CW-1:0]         reopen_c;
	logic [CW-1:0]         abort_c;
	logic [CW-1:0]         hb_c;
	logic                  busy_zero;
	logic [7:0]            busy_up;
	logic [7:0]            busy_down;
	logic signed [7:0]     r_eff;
	logic                  r_pos;

	// Elapsed ticks since the mark; a negative distance counts as zero.
	assign diff = now - mark;
	assign elapsed = diff[TICK_WIDTH-1] ? '0 : CW'(diff);
	assign reopen_c = CW'(cfg.reopen_delay);
	assign abort_c = CW'(cfg.abort_timeout);
	assign hb_c = CW'(cfg.heartbeat_interval);

	// Saturating busy count neighbors.
	assign busy_zero = (ctl.busy == 8'd0);
	assign busy_up = (ctl.busy == 8'hFF) ? ctl.busy : ctl.busy + 8'd1;
	assign busy_down = busy_zero ? ctl.busy : ctl.busy - 8'd1;

	// A zero result is taken as success with value one.
	assign r_eff = (result == 8'sd0) ? 8'sd1 : result;
	assign r_pos = ~r_eff[7];

	always_comb begin
		ctl_next = ctl;
		mark_next = mark;
		verdict = V_INVALID;
		action = ACT_NONE;
		step_return = 8'sd0;
		if (command == CMD_CHECK) begin
			// Check transaction: timing rules and verdict.
			case (ctl.link_status)
				ST_INVALID: begin
					if (busy_zero && !(mark != '0 && elapsed < reopen_c)) begin
						mark_next = now;
						ctl_next.abort_pending = 1'b0;
						ctl_next.hb_phase = HB_CHECKING;
						ctl_next.busy = busy_up;
						verdict = V_SUCCESS;
					end
				end
				ST_OPENING, ST_OPENED: begin
					if (elapsed > abort_c) begin
						mark_next = now;
						ctl_next.abort_pending = 1'b1;
						verdict = V_ABORT;
					end else if (ctl.abort_pending || ctl.link_status == ST_OPENING) begin
						if (busy_zero) begin
							ctl_next.link_status = ST_CLOSING;
							ctl_next.busy = busy_up;
							verdict = V_SUCCESS;
						end
					end else if (!(elapsed < hb_c) && ctl.hb_phase == HB_NONE) begin
						ctl_next.hb_phase = HB_CHECKING;
						ctl_next.busy = busy_up;
						verdict = V_SUCCESS;
					end
				end
				ST_CLOSING: begin
					if (busy_zero) begin
						ctl_next.busy = busy_up;
						verdict = V_SUCCESS;
					end
				end
				ST_CLOSED: begin
					if (busy_zero) begin
						if (!cfg.auto_reopen) begin
							ctl_next.link_status = ST_INVALID;
							mark_next = now;
							ctl_next.abort_pending = 1'b0;
						end else begin
							ctl_next.busy = busy_up;
							verdict = V_SUCCESS;
						end
					end
				end
				default: begin
					verdict = V_INVALID;
				end
			endcase
		end else begin
			// Step transaction: advance on the result of the last action.
			step_return = r_eff;
			case (ctl.link_status)
				ST_INVALID, ST_OPENING, ST_OPENED: begin
					if (!r_pos) begin
						// A failure from any of these states aborts the link.
						action = ACT_ABORT;
						ctl_next.link_status = ST_CLOSING;
						ctl_next.busy = busy_down;
					end else if (ctl.link_status == ST_INVALID) begin
						ctl_next.link_status = ST_OPENING;
						action = ACT_OPEN;
						step_return = 8'sd0;
					end else if (ctl.link_status == ST_OPENING) begin
						mark_next = now;
						ctl_next.link_status = ST_OPENED;
						if (cfg.heartbeat_on_open) begin
							ctl_next.hb_phase = HB_DONE;
							action = ACT_HEART;
							step_return = 8'sd0;
						end else begin
							ctl_next.hb_phase = HB_NONE;
							ctl_next.busy = busy_down;
							step_return = 8'sd1;
						end
					end else if (ctl.hb_phase == HB_CHECKING) begin
						ctl_next.hb_phase = HB_DONE;
						action = ACT_HEART;
						step_return = 8'sd0;
					end else begin
						mark_next = now;
						ctl_next.hb_phase = HB_NONE;
						ctl_next.busy = busy_down;
					end
				end
				ST_CLOSING: begin
					ctl_next.link_status = ST_CLOSED;
					action = ACT_CLOSE;
					step_return = 8'sd0;
				end
				ST_CLOSED: begin
					ctl_next.busy = busy_down;
				end
				default: begin
					step_return = r_eff;
				end
			endcase
		end
	end

endmodule

>>> rtl/connection_lifecycle_supervisor.sv
// Top level of the connection lifecycle supervisor: handshakes, registers and assertions.
// Depends on cls_pkg and cls_step_logic.
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+--------------------
//  in       | command, now_tick, action_result                | in_valid / in_ready
//  out      | verdict, action, step_return, link_state, busy_res | out_valid / out_ready
//  cfg      | cfg_index, cfg_data                             | cfg_write, no wait
//
// Each transaction passes an input register and a result register; one transaction per cycle
// is sustained while the output is not stalled. The state update is one pass of the step logic,
// so the next transaction sees it at once. Reset clears link state and loads the
// configuration defaults. A stalled output holds its result; the input register still
// takes one transaction while the output waits.
`timescale 1ns / 1ps

module connection_lifecycle_supervisor #(
	parameter int TICK_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [cls_pkg::NOW_W-1:0]       now_tick,
	input  logic signed [7:0]               action_result,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      verdict,
	output logic [2:0]                      action,
	output logic signed [7:0]               step_return,
	output logic [2:0]                      link_state,
	output logic [7:0]                      busy_res,
	input  logic                            cfg_write,
	input  logic [2:0]                      cfg_index,
	input  logic [cls_pkg::CFG_W-1:0]       cfg_data
);
	import cls_pkg::*;

	cfg_t                  cfg_q;
	ctl_t                  ctl_q;
	ctl_t                  ctl_next;
	logic [TICK_WIDTH-1:0] mark_q;
	logic [TICK_WIDTH-1:0] mark_next;

	logic                  valid_s1;
	logic                  command_s1;
	logic [TICK_WIDTH-1:0] now_s1;
	logic signed [7:0]     result_s1;
	logic                  advance;

	logic [1:0]            verdict_c;
	logic [2:0]            action_c;
	logic signed [7:0]     return_c;

	logic                  out_valid_q;
	logic [1:0]            verdict_q;
	logic [2:0]            action_q;
	logic signed [7:0]     return_q;
	logic [2:0]            link_state_q;
	logic [7:0]            busy_q;

	// Result register moves when it is empty or being taken.
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reopen_delay <= RST_REOPEN_DELAY;
			cfg_q.abort_timeout <= RST_ABORT_TIMEOUT;
			cfg_q.heartbeat_interval <= RST_HB_INTERVAL;
			cfg_q.auto_reopen <= 1'b1;
			cfg_q.heartbeat_on_open <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_REOPEN_DELAY:  cfg_q.reopen_delay <= cfg_data;
				REG_ABORT_TIMEOUT: cfg_q.abort_timeout <= cfg_data;
				REG_HB_INTERVAL:   cfg_q.heartbeat_interval <= cfg_data;
				REG_AUTO_REOPEN:   cfg_q.auto_reopen <= cfg_data[0];
				REG_HB_ON_OPEN:    cfg_q.heartbeat_on_open <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			now_s1 <= TICK_WIDTH'(now_tick);
			result_s1 <= action_result;
		end
	end

	// Step logic between the input register and the result register.
	cls_step_logic #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_step (
		.command    (command_s1),
		.now        (now_s1),
		.result     (result_s1),
		.cfg        (cfg_q),
		.ctl        (ctl_q),
		.mark       (mark_q),
		.ctl_next   (ctl_next),
		.mark_next  (mark_next),
		.verdict    (verdict_c),
		.action     (action_c),
		.step_return(return_c)
	);

	// Link state, updated once per processed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.link_status <= ST_INVALID;
			ctl_q.hb_phase <= HB_NONE;
			ctl_q.abort_pending <= 1'b0;
			ctl_q.busy <= 8'd0;
			mark_q <= '0;
		end else if (valid_s1 && advance) begin
			ctl_q <= ctl_next;
			mark_q <= mark_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			verdict_q <= verdict_c;
			action_q <= action_c;
			return_q <= return_c;
			link_state_q <= ctl_next.link_status;
			busy_q <= ctl_next.busy;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign action = action_q;
	assign step_return = return_q;
	assign link_state = link_state_q;
	assign busy_res = busy_q;

`ifndef SYNTHESIS
	// A check transaction never requests an action.
	a_check_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q != V_INVALID) |-> (action_q == ACT_NONE && return_q == 8'sd0))
		else $error("check result carries an action");

	// The busy count moves by at most one per cycle.
	a_busy_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.busy == $past(ctl_q.busy)) || (ctl_q.busy == $past(ctl_q.busy) + 8'd1)
		|| (ctl_q.busy == $past(ctl_q.busy) - 8'd1))
		else $error("busy count jumped");

	// While a result waits, the held state matches the reported state.
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> (ctl_q.link_status == link_state_q && ctl_q.busy == busy_q))
		else $error("held result disagrees with link state");
`endif

endmodule

>>> tb/cls_link_checker.sv
// Checker for the connection lifecycle supervisor: tracks the link state, predicts each result.
// Watches the input, output and configuration ports; reports a failure count to the top.
// Depends on cls_pkg.
`timescale 1ns / 1ps

module cls_link_checker
	import cls_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     command,
	input  logic [NOW_W-1:0]         now_tick,
	input  logic signed [7:0]        action_result,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [1:0]               verdict,
	input  logic [2:0]               action,
	input  logic signed [7:0]        step_return,
	input  logic [2:0]               link_state,
	input  logic [7:0]               busy_res,
	input  logic                     cfg_write,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output int                       mismatch_count,
	output int                       results_pending
);

	// One result transaction as the block should produce it.
	typedef struct packed {
		logic [1:0] verdict;
		logic [2:0] action;
		logic [7:0] step_return;
		logic [2:0] link_state;
		logic [7:0] busy;
	} link_result_t;

	link_result_t expected_results[$];

	// Copy of the configuration registers.
	logic [CFG_W-1:0] cfg_reopen;
	logic [CFG_W-1:0] cfg_abort;
	logic [CFG_W-1:0] cfg_hb_int;
	logic             cfg_auto_reopen;
	logic             cfg_hb_on_open;

	// Copy of the link state.
	logic [2:0]       lnk_state;
	logic [1:0]       hb_phase;
	logic [NOW_W-1:0] tick_mark;
	logic             abort_armed;
	logic [7:0]       busy_cnt;

	// Applies one input transaction to the link copy and returns the result it should give.
	function automatic link_result_t predict_link_item(input logic cmd,
			input logic [NOW_W-1:0] now, input logic signed [7:0] raw);
		link_result_t res;
		logic [NOW_W-1:0] span;
		logic signed [7:0] r;
		logic grant;
		logic opened_path;
		res = '0;
		res.verdict = V_INVALID;
		res.action = ACT_NONE;
		// Elapsed ticks since the mark; a mark in the future counts as no time at all.
		span = now - tick_mark;
		if (span[NOW_W-1])
			span = '0;
		r = (raw == 8'sd0) ? 8'sd1 : raw;
		if (cmd == CMD_CHECK) begin
			grant = 1'b0;
			case (lnk_state)
				ST_INVALID: begin
					if (busy_cnt == 8'd0 && !(tick_mark != '0 && span < cfg_reopen)) begin
						tick_mark = now;
						abort_armed = 1'b0;
						hb_phase = HB_CHECKING;
						grant = 1'b1;
					end
				end
				ST_OPENING, ST_OPENED: begin
					if (span > cfg_abort) begin
						tick_mark = now;
						abort_armed = 1'b1;
						res.verdict = V_ABORT;
					end else if (abort_armed || lnk_state == ST_OPENING) begin
						if (busy_cnt == 8'd0) begin
							lnk_state = ST_CLOSING;
							grant = 1'b1;
						end
					end else if (span >= cfg_hb_int && hb_phase == HB_NONE) begin
						hb_phase = HB_CHECKING;
						grant = 1'b1;
					end
				end
				ST_CLOSING: begin
					grant = (busy_cnt == 8'd0);
				end
				ST_CLOSED: begin
					if (busy_cnt == 8'd0) begin
						if (cfg_auto_reopen) begin
							grant = 1'b1;
						end else begin
							lnk_state = ST_INVALID;
							tick_mark = now;
							abort_armed = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
			if (grant) begin
				res.verdict = V_SUCCESS;
				if (busy_cnt != 8'd255)
					busy_cnt = busy_cnt + 8'd1;
			end
		end else begin
			opened_path = 1'b0;
			case (lnk_state)
				// A failed result while invalid runs on into the opened handling.
				ST_INVALID, ST_OPENING: begin
					if (lnk_state == ST_INVALID && r > 0) begin
						lnk_state = ST_OPENING;
						res.action = ACT_OPEN;
						res.step_return = 8'd0;
					end else if (r > 0) begin
						tick_mark = now;
						lnk_state = ST_OPENED;
						if (cfg_hb_on_open) begin
							hb_phase = HB_CHECKING;
							opened_path = 1'b1;
						end else begin
							hb_phase = HB_NONE;
							if (busy_cnt != 8'd0)
								busy_cnt = busy_cnt - 8'd1;
							res.step_return = 8'd1;
						end
					end else begin
						opened_path = 1'b1;
					end
				end
				ST_OPENED: begin
					opened_path = 1'b1;
				end
				ST_CLOSING: begin
					lnk_state = ST_CLOSED;
					res.action = ACT_CLOSE;
					res.step_return = 8'd0;
				end
				ST_CLOSED: begin
					if (busy_cnt != 8'd0)
						busy_cnt = busy_cnt - 8'd1;
					res.step_return = r;
				end
				default: begin
					res.step_return = r;
				end
			endcase
			// Opened handling: a pending heartbeat is requested, a success refreshes the mark,
			// and a failure aborts the link.
			if (opened_path) begin
				if (r > 0 && hb_phase == HB_CHECKING) begin
					hb_phase = HB_DONE;
					res.action = ACT_HEART;
					res.step_return = 8'd0;
				end else begin
					if (r > 0) begin
						tick_mark = now;
						hb_phase = HB_NONE;
					end else begin
						res.action = ACT_ABORT;
						lnk_state = ST_CLOSING;
					end
					if (busy_cnt != 8'd0)
						busy_cnt = busy_cnt - 8'd1;
					res.step_return = r;
				end
			end
		end
		res.link_state = lnk_state;
		res.busy = busy_cnt;
		return res;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t ns: %s wrong, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Compare results, follow register writes and predict each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		link_result_t want;
		if (!arst_n) begin
			cfg_reopen = RST_REOPEN_DELAY;
			cfg_abort = RST_ABORT_TIMEOUT;
			cfg_hb_int = RST_HB_INTERVAL;
			cfg_auto_reopen = 1'b1;
			cfg_hb_on_open = 1'b0;
			lnk_state = ST_INVALID;
			hb_phase = HB_NONE;
			tick_mark = '0;
			abort_armed = 1'b0;
			busy_cnt = 8'd0;
			expected_results.delete();
			mismatch_count = 0;
			results_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: result transaction with nothing expected", $time);
				end else begin
					want = expected_results.pop_front();
					check_field("verdict", want.verdict, verdict);
					check_field("action", want.action, action);
					check_field("step_return", $signed(want.step_return), $signed(step_return));
					check_field("link_state", want.link_state, link_state);
					check_field("busy_res", want.busy, busy_res);
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_REOPEN_DELAY:  cfg_reopen = cfg_data;
					REG_ABORT_TIMEOUT: cfg_abort = cfg_data;
					REG_HB_INTERVAL:   cfg_hb_int = cfg_data;
					REG_AUTO_REOPEN:   cfg_auto_reopen = cfg_data[0];
					REG_HB_ON_OPEN:    cfg_hb_on_open = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_link_item(command, now_tick, action_result));
			results_pending = expected_results.size();
		end
	end

endmodule

>>> tb/connection_lifecycle_supervisor_tb.sv
// Testbench top for the connection lifecycle supervisor: clock, reset, stimulus and verdict.
// Depends on cls_pkg, connection_lifecycle_supervisor and cls_link_checker.
`timescale 1ns / 1ps

module connection_lifecycle_supervisor_tb;
	import cls_pkg::*;

	localparam int ITEMS_PER_PHASE = 116;
	localparam int RX_HOLD_CYCLES = 120;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    command;
	logic [NOW_W-1:0]        now_tick;
	logic signed [7:0]       action_result;
	logic                    out_valid;
	logic                    out_ready;
	logic [1:0]              verdict;
	logic [2:0]              action;
	logic signed [7:0]       step_return;
	logic [2:0]              link_state;
	logic [7:0]              busy_res;
	logic                    cfg_write;
	logic [2:0]              cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	int mismatch_count;
	int results_pending;

	// Idle rates in percent and the request for one long receiver stall.
	int tx_idle_pct;
	int rx_idle_pct;
	bit rx_hold_request;

	// Tick of the emulated client and the settings it paces itself by.
	logic [NOW_W-1:0] tick_now;
	logic [CFG_W-1:0] cur_reopen;
	logic [CFG_W-1:0] cur_abort;
	logic [CFG_W-1:0] cur_hb_int;

	connection_lifecycle_supervisor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.now_tick      (now_tick),
		.action_result (action_result),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.verdict       (verdict),
		.action        (action),
		.step_return   (step_return),
		.link_state    (link_state),
		.busy_res      (busy_res),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	cls_link_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.now_tick        (now_tick),
		.action_result   (action_result),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.action          (action),
		.step_return     (step_return),
		.link_state      (link_state),
		.busy_res        (busy_res),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard limit on the run.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request) begin
				rx_hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Offers one input transaction, after random idle cycles; called at a falling edge.
	task automatic send_item(input logic cmd, input logic [NOW_W-1:0] tick,
			input logic signed [7:0] res);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		now_tick <= tick;
		action_result <= res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering and waits until every result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
	endtask

	// Writes all five registers, one per cycle.
	task automatic apply_settings(input logic [CFG_W-1:0] reopen, input logic [CFG_W-1:0] abort_t,
			input logic [CFG_W-1:0] hb_int, input logic auto_re, input logic hb_open);
		logic [CFG_W-1:0] values [5];
		values[REG_REOPEN_DELAY] = reopen;
		values[REG_ABORT_TIMEOUT] = abort_t;
		values[REG_HB_INTERVAL] = hb_int;
		values[REG_AUTO_REOPEN] = CFG_W'(auto_re);
		values[REG_HB_ON_OPEN] = CFG_W'(hb_open);
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= values[i];
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		cur_reopen = reopen;
		cur_abort = abort_t;
		cur_hb_int = hb_int;
	endtask

	// Moves the client tick: often small steps, often near one of the thresholds,
	// sometimes backward or to anywhere at all.
	task automatic next_tick();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			tick_now = tick_now + $urandom_range(0, 3);
		else if (roll < 60)
			tick_now = tick_now + cur_hb_int + $urandom_range(0, 2);
		else if (roll < 72)
			tick_now = tick_now + cur_abort + $urandom_range(0, 2);
		else if (roll < 84)
			tick_now = tick_now + cur_reopen + $urandom_range(0, 2);
		else if (roll < 92)
			tick_now = tick_now + $urandom_range(0, 1000);
		else if (roll < 97)
			tick_now = tick_now - $urandom_range(1, 5000);
		else
			tick_now = $urandom();
	endtask

	// Stimulus and verdict.
	initial begin
		int items;
		int roll;
		logic signed [7:0] res;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_CHECK;
		now_tick = '0;
		action_result = '0;
		cfg_write = 1'b0;
		cfg_index = REG_REOPEN_DELAY;
		cfg_data = '0;
		rx_hold_request = 1'b0;
		tx_idle_pct = 18;
		rx_idle_pct = 86;
		cur_reopen = RST_REOPEN_DELAY;
		cur_abort = RST_ABORT_TIMEOUT;
		cur_hb_int = RST_HB_INTERVAL;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed walk at the reset settings: open, heartbeat, the thresholds exactly,
		// abort, close, and a closed link that stays closed.
		send_item(CMD_CHECK, 32'd0, 8'sd0);           // mark still zero: no reopen delay
		send_item(CMD_CHECK, 32'd5, 8'sd0);           // busy, so invalid
		send_item(CMD_STEP, 32'd6, 8'sd0);            // zero result counts as success
		send_item(CMD_STEP, 32'd100, 8'sd127);        // open succeeded
		send_item(CMD_CHECK, 32'd10099, 8'sd0);       // one short of the heartbeat interval
		send_item(CMD_CHECK, 32'd10100, 8'sd0);       // heartbeat interval reached
		send_item(CMD_CHECK, 32'd10101, 8'sd0);       // heartbeat already in progress
		send_item(CMD_STEP, 32'd10102, 8'sd5);        // heartbeat requested
		send_item(CMD_STEP, 32'd20000, 8'sd1);        // heartbeat answered
		send_item(CMD_STEP, 32'd20000, 8'sd1);        // plain success refreshes the mark
		send_item(CMD_CHECK, 32'd50000, 8'sd0);       // exactly the abort timeout: no abort
		send_item(CMD_CHECK, 32'd80001, 8'sd0);       // past the timeout: abort
		send_item(CMD_CHECK, 32'd80002, 8'sd0);       // abort pending but busy
		send_item(CMD_STEP, 32'd80002, -8'sd128);     // failure aborts the link
		send_item(CMD_CHECK, 32'd80003, 8'sd0);       // closing link granted
		send_item(CMD_STEP, 32'd80004, -8'sd1);       // close requested
		send_item(CMD_STEP, 32'd80005, -8'sd1);       // close outcome
		send_item(CMD_CHECK, 32'd80006, 8'sd0);       // closed link kept closed
		send_item(CMD_STEP, 32'd80007, 8'sd3);
		wait_drained();

		// Closed link returns to invalid, reopen delay, failure while invalid.
		apply_settings(RST_REOPEN_DELAY, RST_ABORT_TIMEOUT, RST_HB_INTERVAL, 1'b0, 1'b0);
		send_item(CMD_CHECK, 32'd80010, 8'sd0);
		send_item(CMD_CHECK, 32'd83009, 8'sd0);       // one short of the reopen delay
		send_item(CMD_STEP, 32'd83010, -8'sd5);       // failure while invalid
		send_item(CMD_CHECK, 32'hFFFF_FFFF, 8'sd0);
		tick_now = 32'd83100;

		// Random phases, each with its own settings and one of three idle patterns.
		for (int phase = 1; phase <= 8; phase++) begin
			wait_drained();
			case (phase)
				1: apply_settings('0, '0, '0, 1'b0, 1'b1);
				2: apply_settings('1, '1, '1, 1'b0, 1'b0);
				3: apply_settings(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 60)),
						CFG_W'($urandom_range(0, 30)), 1'b0, 1'($urandom_range(0, 1)));
				4: apply_settings(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 60)),
						CFG_W'($urandom_range(0, 30)), 1'b1, 1'b1);
				5: apply_settings(CFG_W'($urandom_range(0, 5000)),
						CFG_W'($urandom_range(0, 5000)), CFG_W'($urandom_range(0, 5000)),
						1'($urandom_range(0, 1)), 1'b0);
				default: apply_settings(CFG_W'($urandom_range(0, 40)),
						CFG_W'($urandom_range(0, 120)), CFG_W'($urandom_range(0, 60)),
						1'b0, 1'($urandom_range(0, 1)));
			endcase
			if (phase <= 2) begin
				tx_idle_pct = 18;
				rx_idle_pct = 86;
			end else if (phase <= 5) begin
				tx_idle_pct = 86;
				rx_idle_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (phase == 7)
				rx_hold_request = 1'b1;
			items = 0;
			while (items < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 10) begin
					// Noise: any command, any tick, any result.
					send_item(1'($urandom_range(0, 1)), $urandom(), 8'($urandom_range(0, 255)));
					items++;
				end else begin
					// A client session: a check, then the steps that answer it.
					next_tick();
					send_item(CMD_CHECK, tick_now, 8'($urandom_range(0, 255)));
					items++;
					repeat ($urandom_range(0, 3)) begin
						roll = $urandom_range(0, 99);
						if (roll < 75)
							res = 8'($urandom_range(1, 127));
						else if (roll < 85)
							res = 8'sd0;
						else
							res = 8'($urandom_range(128, 255));
						if ($urandom_range(0, 3) == 0)
							next_tick();
						else
							tick_now = tick_now + $urandom_range(0, 2);
						send_item(CMD_STEP, tick_now, res);
						items++;
					end
				end
			end
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
rtl/cls_pkg.sv
rtl/cls_step_logic.sv
rtl/connection_lifecycle_supervisor.sv
tb/cls_link_checker.sv
tb/connection_lifecycle_supervisor_tb.sv
